>>> rtl/core/ufla_pkg.sv
// ----------------------------------------------------------------------------
// ufla_pkg
// Shared constants, codes, types and helpers of the uart receive fifo and
// line assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package ufla_pkg;

  localparam int FIFO_DEPTH  = 64;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int MAX_RESULTS = 64;
  localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

  typedef logic [PTR_W-1:0] ptr_t;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_TICK = 3'd1;
  localparam logic [2:0] OP_LINE = 3'd2;
  localparam logic [2:0] OP_BIN  = 3'd3;
  localparam logic [2:0] OP_POP  = 3'd4;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_RAW   = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PR_LO = 8'h20;
  localparam logic [7:0] CH_PR_HI = 8'h7E;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] length;
    logic       timed_out;
  } res_t;

  // sequencer to result buffer
  typedef struct packed {
    logic emit;
    logic flush;
    res_t res;
  } rb_req_t;

  // result buffer to sequencer
  typedef struct packed {
    logic can_emit;
    logic can_flush;
  } rb_stat_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    if (p == ptr_t'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

  // cr and lf fall outside the printable range
  function automatic logic is_print(input logic [7:0] b);
    return (b >= CH_PR_LO) && (b <= CH_PR_HI);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ufla_if.sv
// ----------------------------------------------------------------------------
// ufla channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufla_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  data;
  logic [7:0]  max_len;
  logic [15:0] timeout_ticks;

  modport source (output valid, output op, output data, output max_len,
                  output timeout_ticks, input ready);
  modport sink   (input valid, input op, input data, input max_len,
                  input timeout_ticks, output ready);
endinterface

interface ufla_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_res;
  logic [7:0] length;
  logic       timed_out;
  logic       last;

  modport source (output valid, output kind, output data_res, output length,
                  output timed_out, output last, input ready);
  modport sink   (input valid, input kind, input data_res, input length,
                  input timed_out, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ufla_fifo_mem.sv
// ----------------------------------------------------------------------------
// ufla_fifo_mem
// Receive byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ufla_fifo_mem import ufla_pkg::*; (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire ptr_t       wr_addr,
  input  wire logic [7:0] wr_data,
  input  wire logic       rd_en,
  input  wire ptr_t       rd_addr,
  output logic [7:0]      rd_data
);

  logic [7:0] mem [FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ufla_res_buf.sv
// ----------------------------------------------------------------------------
// ufla_res_buf
// Holds the newest result until the next one or the end of the transaction
// decides its last flag, then hands it to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ufla_res_buf import ufla_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire rb_req_t req,
  output rb_stat_t     stat,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic [1:0]   out_kind,
  output logic [7:0]   out_data_res,
  output logic [7:0]   out_length,
  output logic         out_timed_out,
  output logic         out_last
);

  logic pend_vld_r, pend_vld_nxt;
  res_t pend_r, pend_nxt;
  logic out_vld_r, out_vld_nxt;
  res_t out_res_r, out_res_nxt;
  logic out_last_r, out_last_nxt;
  logic out_free;

  assign out_free       = !out_vld_r || out_ready;
  assign stat.can_emit  = !pend_vld_r || out_free;
  assign stat.can_flush = !pend_vld_r || out_free;

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_res_nxt  = out_res_r;
    out_last_nxt = out_last_r;
    if (req.emit) begin
      if (pend_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = pend_r;
        out_last_nxt = 1'b0;
      end
      pend_vld_nxt = 1'b1;
      pend_nxt     = req.res;
    end else if (req.flush && pend_vld_r) begin
      out_vld_nxt  = 1'b1;
      out_res_nxt  = pend_r;
      out_last_nxt = 1'b1;
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_kind      = out_res_r.kind;
  assign out_data_res  = out_res_r.data;
  assign out_length    = out_res_r.length;
  assign out_timed_out = out_res_r.timed_out;
  assign out_last      = out_last_r;

  // a held result must never be overwritten while the output is still busy
  assert property (@(posedge clk) disable iff (!rst_n)
    req.emit && pend_vld_r |-> out_free)
    else $error("ufla_res_buf: result pushed while output busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    req.flush && pend_vld_r |-> out_free)
    else $error("ufla_res_buf: flush while output busy");

endmodule

`default_nettype wire

>>> rtl/core/ufla_seq.sv
// ----------------------------------------------------------------------------
// ufla_seq
// Sequencer: fifo pointers, read state and the byte classifier, stepping each
// buffered byte through a check and an evaluate state and the shared compare logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ufla_seq import ufla_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [7:0]  in_data,
  input  wire logic [7:0]  in_max_len,
  input  wire logic [15:0] in_timeout_ticks,
  output logic             wr_en,
  output ptr_t             wr_addr,
  output logic [7:0]       wr_data,
  output logic             rd_en,
  output ptr_t             rd_addr,
  input  wire logic [7:0]  rd_data,
  output rb_req_t          req,
  input  wire rb_stat_t    stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]        state_r, state_nxt;
  ptr_t              wp_r, wp_nxt;
  ptr_t              rp_r, rp_nxt;
  logic              active_r, active_nxt;
  logic              bin_r, bin_nxt;
  logic [7:0]        kept_r, kept_nxt;
  logic [7:0]        limit_r, limit_nxt;
  logic [15:0]       ticks_r, ticks_nxt;
  logic [NCNT_W-1:0] n_r, n_nxt;

  always_comb begin
    logic [15:0] tick_dec;
    logic [7:0]  kept_inc;
    logic        keep;

    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    active_nxt = active_r;
    bin_nxt    = bin_r;
    kept_nxt   = kept_r;
    limit_nxt  = limit_r;
    ticks_nxt  = ticks_r;
    n_nxt      = n_r;
    in_ready   = (state_r == S_IDLE);
    wr_en      = 1'b0;
    wr_addr    = wp_r;
    wr_data    = in_data;
    rd_en      = 1'b0;
    rd_addr    = rp_r;
    req        = '0;
    tick_dec   = (ticks_r != 16'd0) ? ticks_r - 16'd1 : ticks_r;
    kept_inc   = kept_r + 8'd1;
    keep       = bin_r || is_print(rd_data);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt = '0;
          case (in_op) inside
            OP_PUSH: begin
              if (ptr_inc(wp_r) != rp_r) begin
                wr_en  = 1'b1;
                wp_nxt = ptr_inc(wp_r);
              end
              state_nxt = S_CHK;
            end
            OP_TICK: begin
              state_nxt = S_FLUSH;
              if (active_r) begin
                ticks_nxt = tick_dec;
                if (tick_dec == 16'd0) begin
                  active_nxt    = 1'b0;
                  req.emit      = 1'b1;
                  req.res       = '{KIND_END, 8'd0, kept_r, 1'b1};
                  n_nxt         = NCNT_W'(1);
                end else begin
                  state_nxt = S_CHK;
                end
              end
            end
            OP_LINE, OP_BIN: begin
              active_nxt = 1'b1;
              bin_nxt    = (in_op == OP_BIN);
              kept_nxt   = 8'd0;
              limit_nxt  = in_max_len;
              ticks_nxt  = in_timeout_ticks;
              state_nxt  = S_FLUSH;
              if (in_max_len == 8'd0 || in_timeout_ticks == 16'd0) begin
                // zero limit ends plainly, zero timeout ends as timed out
                active_nxt = 1'b0;
                req.emit   = 1'b1;
                req.res    = '{KIND_END, 8'd0, 8'd0, (in_max_len != 8'd0)};
                n_nxt      = NCNT_W'(1);
              end else begin
                state_nxt = S_CHK;
              end
            end
            OP_POP: begin
              if (rp_r == wp_r) begin
                req.emit  = 1'b1;
                req.res   = '{KIND_EMPTY, 8'd0, 8'd0, 1'b0};
                n_nxt     = NCNT_W'(1);
                state_nxt = S_FLUSH;
              end else begin
                rd_en     = 1'b1;
                rp_nxt    = ptr_inc(rp_r);
                state_nxt = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CHK: begin
        if (active_r && rp_r != wp_r && n_r < NCNT_W'(MAX_RESULTS - 1)) begin
          rd_en     = 1'b1;
          rp_nxt    = ptr_inc(rp_r);
          state_nxt = S_EVAL;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_EVAL: begin
        if (keep) begin
          if (stat.can_emit) begin
            req.emit  = 1'b1;
            req.res   = '{KIND_CHAR, rd_data, 8'd0, 1'b0};
            n_nxt     = n_r + NCNT_W'(1);
            kept_nxt  = kept_inc;
            state_nxt = (kept_inc >= limit_r) ? S_FIN : S_CHK;
          end
        end else if (!bin_r && rd_data == CH_LF && kept_r != 8'd0) begin
          if (stat.can_emit) begin
            req.emit   = 1'b1;
            req.res    = '{KIND_END, 8'd0, kept_r, 1'b0};
            n_nxt      = n_r + NCNT_W'(1);
            active_nxt = 1'b0;
            state_nxt  = S_FLUSH;
          end
        end else begin
          // cr, leading lf and unprintable bytes are dropped
          state_nxt = S_CHK;
        end
      end
      S_FIN: begin
        if (stat.can_emit) begin
          req.emit   = 1'b1;
          req.res    = '{KIND_END, 8'd0, kept_r, 1'b0};
          n_nxt      = n_r + NCNT_W'(1);
          active_nxt = 1'b0;
          state_nxt  = S_FLUSH;
        end
      end
      S_POP: begin
        req.emit  = 1'b1;
        req.res   = '{KIND_RAW, rd_data, 8'd0, 1'b0};
        n_nxt     = NCNT_W'(1);
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        if (stat.can_flush) begin
          req.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      rp_r     <= '0;
      active_r <= 1'b0;
      bin_r    <= 1'b0;
      kept_r   <= 8'd0;
      limit_r  <= 8'd0;
      ticks_r  <= 16'd0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      active_r <= active_nxt;
      bin_r    <= bin_nxt;
      kept_r   <= kept_nxt;
      limit_r  <= limit_nxt;
      ticks_r  <= ticks_nxt;
      n_r      <= n_nxt;
    end
  end

  // result bound stops the drain for this transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK && n_r >= NCNT_W'(MAX_RESULTS - 1) |=> state_r == S_FLUSH)
    else $error("ufla_seq: drain ran past the result bound");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> active_r)
    else $error("ufla_seq: byte evaluated with no read active");

  // a write never makes the fifo look empty
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> wp_r != rp_r)
    else $error("ufla_seq: push overran the read pointer");

endmodule

`default_nettype wire

>>> rtl/core/uart_rx_fifo_line_assembler_core.sv
// Timing: a raw pop reads the byte store through its registered read port. A push or tick
// that drains steps each buffered byte through a registered fifo read, then classify, and
// a finish state for an end at the length limit; a stalled output holds the sequencer once
// two results are waiting.
// Throughput: one transaction at a time; in_ready is high only while idle.
// Reset (synchronous, active low) clears pointers, read state and result valid flags, not the byte store.
// ----------------------------------------------------------------------------
// uart_rx_fifo_line_assembler_core
// Uart receive ring buffer with raw pop, line reader and binary reader.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rx_fifo_line_assembler_core import ufla_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ufla_in_if.sink     in_ch,
  ufla_out_if.source  out_ch
);

  logic       wr_en;
  ptr_t       wr_addr;
  logic [7:0] wr_data;
  logic       rd_en;
  ptr_t       rd_addr;
  logic [7:0] rd_data;
  rb_req_t    req;
  rb_stat_t   stat;

  ufla_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_op            (in_ch.op),
    .in_data          (in_ch.data),
    .in_max_len       (in_ch.max_len),
    .in_timeout_ticks (in_ch.timeout_ticks),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .req              (req),
    .stat             (stat)
  );

  ufla_fifo_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ufla_res_buf u_res (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .stat          (stat),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_kind      (out_ch.kind),
    .out_data_res  (out_ch.data_res),
    .out_length    (out_ch.length),
    .out_timed_out (out_ch.timed_out),
    .out_last      (out_ch.last)
  );

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pushes, ticks, line and binary reads and raw pops into the uart
// receive fifo, predicts results from a behavioral copy of the fifo and reader
// state or from typed rows, checks each result against the oldest expected one,
// and idles and stalls both channel sides at random.
// ----------------------------------------------------------------------------

module tb_top;
  import ufla_pkg::*;

  localparam int          CYCLE_LIMIT   = 1_500_000;
  localparam int          RANDOM_ITEMS  = 410;
  localparam int          SETTLE_CYCLES = 300;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [7:0]  ASCII_CR      = 8'h0D;
  localparam logic [2:0]  OP_UNUSED     = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] length;
    logic       timed_out;
    logic       last;
  } rx_res_t;

  // one directed row; typed rows carry their single result inline
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data;
    logic [7:0]  max_len;
    logic [15:0] tmo;
    logic        typed;
    logic [1:0]  kind;
    logic [7:0]  res_data;
    logic [7:0]  res_len;
    logic        res_to;
  } dir_row_t;

  localparam int DIR_ROWS = 27;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{OP_POP,    8'h00, 8'd0,   16'd0,     1'b1, KIND_EMPTY, 8'h00, 8'd0, 1'b0},
    '{OP_TICK,   8'h00, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_LINE,   8'h00, 8'd0,   16'd100,   1'b1, KIND_END,   8'h00, 8'd0, 1'b0},
    '{OP_BIN,    8'h00, 8'd5,   16'd0,     1'b1, KIND_END,   8'h00, 8'd0, 1'b1},
    '{OP_UNUSED, 8'hFF, 8'hFF,  16'hFFFF,  1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h00, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'hFF, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h41, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_POP,    8'h00, 8'd0,   16'd0,     1'b1, KIND_RAW,   8'h00, 8'd0, 1'b0},
    '{OP_LINE,   8'h00, 8'd255, 16'd65535, 1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h0D, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h0A, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_LINE,   8'h00, 8'd10,  16'd3,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h0A, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h20, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h7E, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h1F, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h7F, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_TICK,   8'h00, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_TICK,   8'h00, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_TICK,   8'h00, 8'd0,   16'd0,     1'b1, KIND_END,   8'h00, 8'd2, 1'b1},
    '{OP_BIN,    8'h00, 8'd2,   16'd1000,  1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h0D, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_PUSH,   8'h0A, 8'd0,   16'd0,     1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_LINE,   8'h00, 8'd3,   16'd50,    1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0},
    '{OP_POP,    8'h00, 8'd0,   16'd0,     1'b1, KIND_EMPTY, 8'h00, 8'd0, 1'b0},
    '{OP_BIN,    8'h00, 8'd1,   16'd50,    1'b0, KIND_CHAR,  8'h00, 8'd0, 1'b0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ufla_in_if  in_ch ();
  ufla_out_if out_ch ();

  uart_rx_fifo_line_assembler_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // ---- fifo and reader prediction ----
  logic [7:0]  byte_store [FIFO_DEPTH];
  int unsigned wr_idx    = 0;
  int unsigned rd_idx    = 0;
  logic        reading   = 1'b0;
  logic        bin_read  = 1'b0;
  logic [7:0]  kept_len  = '0;
  logic [7:0]  len_cap   = '0;
  logic [15:0] ticks_rem = '0;

  rx_res_t step_res [$];
  rx_res_t expected_q [$];

  bit quick       = 1'b0;
  int items_done  = 0;
  int fails       = 0;
  int cycles      = 0;
  int rcv_wait    = 0;
  int rcv_draw    = 0;
  int accept_cnt  = 0;
  int accept_seen = 0;
  logic rcv_ready = 1'b0;

  assign out_ch.ready = rcv_ready;

  function automatic void note_result(input logic [1:0] kind, input logic [7:0] d,
                                      input logic [7:0] len, input logic to);
    rx_res_t r;
    r.kind      = kind;
    r.data      = d;
    r.length    = len;
    r.timed_out = to;
    r.last      = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void close_read(input logic to);
    reading = 1'b0;
    note_result(KIND_END, 8'h00, kept_len, to);
  endfunction

  function automatic void drain_fifo();
    logic [7:0] b;
    logic       keep;
    // one item leaves room for at most one end result past the bytes it drains
    while (reading && rd_idx != wr_idx && step_res.size() < MAX_RESULTS - 1) begin
      b      = byte_store[rd_idx];
      rd_idx = (rd_idx + 1) % FIFO_DEPTH;
      if (bin_read) begin
        keep = 1'b1;
      end else if (b == ASCII_CR) begin
        keep = 1'b0;
      end else if (b == CH_LF) begin
        if (kept_len > 0) close_read(1'b0);
        keep = 1'b0;
      end else begin
        keep = (b >= CH_PR_LO) && (b <= CH_PR_HI);
      end
      if (keep) begin
        note_result(KIND_CHAR, b, 8'd0, 1'b0);
        kept_len = kept_len + 8'd1;
        if (kept_len >= len_cap) close_read(1'b0);
      end
    end
  endfunction

  function automatic void model_item(input logic [2:0] op, input logic [7:0] d,
                                     input logic [7:0] ml, input logic [15:0] tmo);
    int unsigned nxt;
    rx_res_t     tail;
    step_res.delete();
    case (op)
      OP_PUSH: begin
        nxt = (wr_idx + 1) % FIFO_DEPTH;
        // full fifo drops the byte
        if (nxt != rd_idx) begin
          byte_store[wr_idx] = d;
          wr_idx = nxt;
        end
        drain_fifo();
      end
      OP_TICK: begin
        if (reading) begin
          if (ticks_rem > 0) ticks_rem = ticks_rem - 16'd1;
          if (ticks_rem == 0) close_read(1'b1);
          else drain_fifo();
        end
      end
      OP_LINE, OP_BIN: begin
        reading   = 1'b1;
        bin_read  = (op == OP_BIN);
        kept_len  = '0;
        len_cap   = ml;
        ticks_rem = tmo;
        if (len_cap == 0) close_read(1'b0);
        else if (ticks_rem == 0) close_read(1'b1);
        else drain_fifo();
      end
      OP_POP: begin
        if (rd_idx == wr_idx) begin
          note_result(KIND_EMPTY, 8'h00, 8'd0, 1'b0);
        end else begin
          note_result(KIND_RAW, byte_store[rd_idx], 8'd0, 1'b0);
          rd_idx = (rd_idx + 1) % FIFO_DEPTH;
        end
      end
      default: begin
      end
    endcase
    if (step_res.size() > 0) begin
      tail      = step_res.pop_back();
      tail.last = 1'b1;
      step_res.push_back(tail);
    end
  endfunction

  // ---- input side ----
  task automatic send_item(input logic [2:0] op, input logic [7:0] d, input logic [7:0] ml,
                           input logic [15:0] tmo, input bit has_typed,
                           input rx_res_t typed);
    int gap;
    gap = quick ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op            = op;
    in_ch.data          = d;
    in_ch.max_len       = ml;
    in_ch.timeout_ticks = tmo;
    in_ch.valid         = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_done++;
    model_item(op, d, ml, tmo);
    if (has_typed) begin
      expected_q.push_back(typed);
    end else begin
      foreach (step_res[i]) expected_q.push_back(step_res[i]);
    end
  endtask

  task automatic send_plain(input logic [2:0] op, input logic [7:0] d, input logic [7:0] ml,
                            input logic [15:0] tmo);
    send_item(op, d, ml, tmo, 1'b0, '0);
  endtask

  // mostly printable text with line breaks mixed in
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return ASCII_CR;
    if (r <= 2) return CH_LF;
    if (r == 3) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(CH_PR_LO, CH_PR_HI));
  endfunction

  task automatic run_directed();
    rx_res_t typed;
    foreach (dir_tab[i]) begin
      typed.kind      = dir_tab[i].kind;
      typed.data      = dir_tab[i].res_data;
      typed.length    = dir_tab[i].res_len;
      typed.timed_out = dir_tab[i].res_to;
      typed.last      = 1'b1;
      send_item(dir_tab[i].op, dir_tab[i].data, dir_tab[i].max_len, dir_tab[i].tmo,
                dir_tab[i].typed, typed);
    end
  endtask

  task automatic run_random();
    int          scen;
    int          n;
    int          r;
    logic [2:0]  op;
    logic [7:0]  ml;
    logic [15:0] tmo;
    while (items_done < RANDOM_ITEMS) begin
      quick = ($urandom_range(0, 4) == 0);
      scen  = $urandom_range(0, 9);
      if (scen <= 4) begin
        // read session: start, then traffic with ticks and the odd pop
        op = ($urandom_range(0, 9) < 7) ? OP_LINE : OP_BIN;
        r  = $urandom_range(0, 19);
        if (r == 0) ml = 8'd0;
        else if (r == 1) ml = 8'd255;
        else if (r <= 3) ml = 8'($urandom_range(0, 255));
        else ml = 8'($urandom_range(1, 24));
        r = $urandom_range(0, 19);
        if (r == 0) tmo = 16'd0;
        else if (r == 1) tmo = 16'hFFFF;
        else if (r == 2) tmo = 16'($urandom_range(0, 65535));
        else tmo = 16'($urandom_range(1, 12));
        send_plain(op, 8'($urandom_range(0, 255)), ml, tmo);
        n = $urandom_range(1, 24);
        repeat (n) begin
          r = $urandom_range(0, 15);
          if (r < 10) send_plain(OP_PUSH, pick_text_byte(), 8'd0, 16'd0);
          else if (r < 13) send_plain(OP_TICK, 8'd0, 8'd0, 16'd0);
          else if (r == 13) send_plain(OP_POP, 8'd0, 8'd0, 16'd0);
          else send_plain(OP_PUSH, 8'($urandom_range(0, 255)), 8'd0, 16'd0);
        end
      end else if (scen <= 6) begin
        // fill without starting a read, past full at times, then a few pops
        n = $urandom_range(0, 70);
        repeat (n) send_plain(OP_PUSH, pick_text_byte(), 8'd0, 16'd0);
        n = $urandom_range(0, 3);
        repeat (n) send_plain(OP_POP, 8'd0, 8'd0, 16'd0);
      end else if (scen == 7) begin
        n = $urandom_range(1, 4);
        repeat (n) send_plain(OP_POP, 8'd0, 8'd0, 16'd0);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_plain(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_PUSH;
    in_ch.data          = '0;
    in_ch.max_len       = '0;
    in_ch.timeout_ticks = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    run_random();
    @(negedge clk);
    in_ch.valid = 1'b0;
    quick = 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    // a drain that keeps nothing can still be running
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---- result side ----
  always @(negedge clk) begin
    if (accept_cnt != accept_seen) begin
      accept_seen = accept_cnt;
      rcv_wait    = rcv_draw;
    end
    if (rcv_wait > 0) begin
      rcv_ready <= 1'b0;
      rcv_wait   = rcv_wait - 1;
    end else begin
      rcv_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rx_res_t got;
    rx_res_t want;
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind      = out_ch.kind;
      got.data      = out_ch.data_res;
      got.length    = out_ch.length;
      got.timed_out = out_ch.timed_out;
      got.last      = out_ch.last;
      if (expected_q.size() == 0) begin
        fails = fails + 1;
        if (fails <= MAX_REPORTS)
          $display("unexpected transaction: kind=%0d data=%h len=%0d to=%0b last=%0b",
                   got.kind, got.data, got.length, got.timed_out, got.last);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          fails = fails + 1;
          if (fails <= MAX_REPORTS)
            $display({"mismatch: exp kind=%0d data=%h len=%0d to=%0b last=%0b",
                      " | got kind=%0d data=%h len=%0d to=%0b last=%0b"},
                     want.kind, want.data, want.length, want.timed_out, want.last,
                     got.kind, got.data, got.length, got.timed_out, got.last);
        end
      end
      rcv_draw   = quick ? 0 : $urandom_range(0, 8);
      accept_cnt = accept_cnt + 1;
    end
  end

endmodule

>>> uart_rx_fifo_line_assembler_core.f
rtl/core/ufla_pkg.sv
rtl/core/ufla_if.sv
rtl/core/ufla_fifo_mem.sv
rtl/core/ufla_res_buf.sv
rtl/core/ufla_seq.sv
rtl/core/uart_rx_fifo_line_assembler_core.sv
test/tb_top.sv
